[rtl/bped_pkg.sv]
// ----------------------------------------------------------------------------
// bped_pkg
// Shared types and constants for the byte-pair expansion decoder.
// ----------------------------------------------------------------------------
package bped_pkg;

    localparam int BYTE_W  = 8;
    localparam int PAIR_W  = 2 * BYTE_W;
    localparam int TBL_DEPTH = 256;

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_TRIPLES = 2'd1,
        PH_DATA    = 2'd2,
        PH_ENDED   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_CODE   = 2'd2
    } pos_t;

    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [PAIR_W-1:0] wr_data;
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
    } tbl_req_t;

endpackage

[rtl/bped_table.sv]
// ----------------------------------------------------------------------------
// bped_table
// Pair table: 256 x 16 memory with per-entry valid bits and registered read.
// ----------------------------------------------------------------------------
module bped_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bped_pkg::tbl_req_t            req,
    output logic [bped_pkg::PAIR_W-1:0]   rd_data,
    output logic                          rd_hit
);

    logic [bped_pkg::PAIR_W-1:0] mem [bped_pkg::TBL_DEPTH];
    logic [bped_pkg::TBL_DEPTH-1:0] valid_reg;
    logic [bped_pkg::PAIR_W-1:0] rd_data_reg;
    logic                        rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

[rtl/byte_pair_expansion_decoder_unit.sv]
// ----------------------------------------------------------------------------
// byte_pair_expansion_decoder_unit
// Decodes a byte-pair compressed stream: parses the pair table header, then
// expands code bytes into their stored pairs and passes other bytes through.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one compressed byte and its
// end_of_stream mark per word. Output channel: out_valid/out_ready carry one
// decoded byte with run_last, stream_done and after_end_error.
// Header words (count byte, then count triples of first byte, second byte,
// code) give no output and are taken one per cycle. A data word passes
// through the input stage, then the output register. A plain data byte
// frees the input stage as it loads; a code with a stored pair yields two
// output words and holds the input until the second loads into the single
// output register. Words after the end mark each give one error word.
// Reset clears the phase, the header counters and all table valid bits; no
// clearing pass is needed. When out_ready is low the output word holds, one
// more word waits in the input stage, and in_ready then drops.
// ----------------------------------------------------------------------------
module byte_pair_expansion_decoder_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bped_pkg::BYTE_W-1:0] in_byte,
    input  logic                        end_of_stream,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bped_pkg::BYTE_W-1:0] out_byte,
    output logic                        run_last,
    output logic                        stream_done,
    output logic                        after_end_error
);

    bped_pkg::phase_t phase_reg, phase_next;
    bped_pkg::pos_t   pos_reg, pos_next;
    logic [bped_pkg::BYTE_W-1:0] entries_reg, entries_next;
    logic [bped_pkg::PAIR_W-1:0] hold_reg, hold_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_err_reg, s1_err_next;
    logic                        s1_eos_reg, s1_eos_next;
    logic                        s1_half_reg, s1_half_next;
    logic [bped_pkg::BYTE_W-1:0] s1_byte_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [bped_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        run_last_reg, run_last_next;
    logic                        done_reg, done_next;
    logic                        err_reg, err_next;

    bped_pkg::tbl_req_t          tbl_req;
    logic [bped_pkg::PAIR_W-1:0] tbl_data;
    logic                        tbl_hit;

    logic accept;
    logic load;
    logic expand;
    logic first;
    logic s1_done;

    bped_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_data),
        .rd_hit  (tbl_hit)
    );

    assign load     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign expand   = !s1_err_reg && tbl_hit;
    assign first    = expand && !s1_half_reg;
    assign s1_done  = load && !first;
    assign in_ready = !s1_valid_reg || s1_done;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        entries_next  = entries_reg;
        hold_next     = hold_reg;
        s1_valid_next = s1_valid_reg && !s1_done;
        s1_err_next   = s1_err_reg;
        s1_eos_next   = s1_eos_reg;
        tbl_req       = '0;
        tbl_req.wr_addr = in_byte;
        tbl_req.wr_data = hold_reg;
        tbl_req.rd_addr = in_byte;
        if (accept)
        begin
            unique case (phase_reg)
                bped_pkg::PH_COUNT:
                begin
                    entries_next = in_byte;
                    pos_next     = bped_pkg::POS_FIRST;
                    phase_next   = (in_byte == '0) ? bped_pkg::PH_DATA : bped_pkg::PH_TRIPLES;
                end
                bped_pkg::PH_TRIPLES:
                begin
                    unique case (pos_reg)
                        bped_pkg::POS_FIRST:
                        begin
                            hold_next[bped_pkg::BYTE_W-1:0] = in_byte;
                            pos_next = bped_pkg::POS_SECOND;
                        end
                        bped_pkg::POS_SECOND:
                        begin
                            hold_next[bped_pkg::PAIR_W-1:bped_pkg::BYTE_W] = in_byte;
                            pos_next = bped_pkg::POS_CODE;
                        end
                        default:
                        begin
                            tbl_req.wr_en = 1'b1;
                            pos_next      = bped_pkg::POS_FIRST;
                            entries_next  = entries_reg - 1'b1;
                            if (entries_reg == bped_pkg::BYTE_W'(1))
                            begin
                                phase_next = bped_pkg::PH_DATA;
                            end
                        end
                    endcase
                end
                bped_pkg::PH_DATA:
                begin
                    tbl_req.rd_en = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_err_next   = 1'b0;
                    s1_eos_next   = end_of_stream;
                    if (end_of_stream)
                    begin
                        phase_next = bped_pkg::PH_ENDED;
                    end
                end
                bped_pkg::PH_ENDED:
                begin
                    s1_valid_next = 1'b1;
                    s1_err_next   = 1'b1;
                    s1_eos_next   = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_half_next   = s1_half_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;
        err_next       = err_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            run_last_next  = !first;
            done_next      = !first && s1_eos_reg && !s1_err_reg;
            err_next       = s1_err_reg;
            if (s1_err_reg)
            begin
                out_byte_next = '0;
            end
            else if (first)
            begin
                out_byte_next = tbl_data[bped_pkg::BYTE_W-1:0];
            end
            else if (expand)
            begin
                out_byte_next = tbl_data[bped_pkg::PAIR_W-1:bped_pkg::BYTE_W];
            end
            else
            begin
                out_byte_next = s1_byte_reg;
            end
            s1_half_next = first;
        end
        if (accept)
        begin
            s1_half_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bped_pkg::PH_COUNT;
            pos_reg       <= bped_pkg::POS_FIRST;
            entries_reg   <= '0;
            hold_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_half_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            entries_reg   <= entries_next;
            hold_reg      <= hold_next;
            s1_valid_reg  <= s1_valid_next;
            s1_half_reg   <= s1_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg   <= s1_err_next;
        s1_eos_reg   <= s1_eos_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
        err_reg      <= err_next;
        if (accept)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign run_last        = run_last_reg;
    assign stream_done     = done_reg;
    assign after_end_error = err_reg;

`ifndef SYNTHESIS
    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bped_pkg::PH_ENDED |=> phase_reg == bped_pkg::PH_ENDED)
        else $error("ended phase left");

    a_half_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_half_reg |-> s1_valid_reg && tbl_hit && !s1_err_reg)
        else $error("second half pending without a stored pair");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_end_error |-> out_byte == '0 && run_last && !stream_done)
        else $error("malformed error word");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_last)
        else $error("stream_done on a non-final word");
`endif

endmodule
